[sv/imbe_pkg.sv]
`default_nettype none
// Package: shared types, codes and constants for the I2C master bit engine.
package imbe_pkg;

    localparam int unsigned HOLD_W    = 8;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned TMO_W     = 15;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned BIT_IDX_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [HOLD_W-1:0] LONG_HOLD_RST  = 8'd2;
    localparam logic [HOLD_W-1:0] SHORT_HOLD_RST = 8'd1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'd0,
        ST_A1      = 5'd1,
        ST_A2      = 5'd2,
        ST_P1      = 5'd3,
        ST_P2      = 5'd4,
        ST_P3      = 5'd5,
        ST_W_LOW   = 5'd6,
        ST_W_HIGH  = 5'd7,
        ST_K1      = 5'd8,
        ST_K2      = 5'd9,
        ST_K_POLL  = 5'd10,
        ST_K_CHECK = 5'd11,
        ST_K_DROP  = 5'd12,
        ST_R_LOW   = 5'd13,
        ST_R_HIGH  = 5'd14,
        ST_R_GAP   = 5'd15,
        ST_R_ACK   = 5'd16,
        ST_R_END   = 5'd17
    } t_step;

    typedef enum logic [FUNC_W-1:0] {
        FN_START    = 3'd0,
        FN_STOP     = 3'd1,
        FN_WRITE    = 3'd2,
        FN_WAIT_ACK = 3'd3,
        FN_READ     = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ACK_OK      = 2'd0,
        ACK_TIMEOUT = 2'd1,
        ACK_NACK    = 2'd2
    } t_ack_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_HOLD  = 2'd0,
        CFG_SHORT_HOLD = 2'd1
    } t_cfg_idx;

endpackage : imbe_pkg
`default_nettype wire

[sv/imbe_ifs.sv]
`default_nettype none
// Interfaces: command tick, pin result and configuration write channels.
interface imbe_cmd_if;
    import imbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 cmd_valid;
    logic [FUNC_W-1:0]    func;
    logic [DATA_W-1:0]    write_data;
    logic                 send_ack;
    logic [TMO_W-1:0]     ack_timeout;
    logic                 sda_in;

    modport source (output valid, cmd_valid, func, write_data, send_ack, ack_timeout,
                    sda_in, input ready);
    modport sink   (input valid, cmd_valid, func, write_data, send_ack, ack_timeout,
                    sda_in, output ready);
endinterface : imbe_cmd_if

interface imbe_res_if;
    import imbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 scl_out;
    logic                 sda_out;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_W-1:0]    read_data;
    logic [STATUS_W-1:0]  ack_status;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_status, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_status, output ready);
endinterface : imbe_res_if

interface imbe_cfg_if;
    import imbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [HOLD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : imbe_cfg_if
`default_nettype wire

[sv/i2c_master_bit_engine_unit.sv]
`default_nettype none
// Top level: I2C master bit engine, one pin-sequencing step per command tick.
//
// Each transfer on i_cmd is one time unit from a prescaler; the engine takes
// one every clock cycle unless o_res stalls and answers each with one transfer
// on o_res carrying the open-drain SCL/SDA drives, busy/done flags, the last
// read byte and the last ACK status. The sequencer state is the result
// register, so a result shows in the cycle after its tick; i_cmd is ready while
// it waits only if it is taken in the same cycle. Sustained rate is one tick
// per cycle unless o_res stalls, set by the single sequencer step between the
// tick and the state register. Commands (start, stop, write byte, wait ACK,
// read byte) are taken only while idle; anything arriving while busy, or an
// undefined code, is dropped. Hold lengths come from the two configuration
// registers (index 0 long hold, index 1 short hold; zero behaves as one tick);
// write them only while the engine is idle. i_cfg is always ready.

module i2c_master_bit_engine_unit
    import imbe_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    imbe_cmd_if.sink   i_cmd,
    imbe_res_if.source o_res,
    imbe_cfg_if.sink   i_cfg
);

    // Configuration registers
    logic [HOLD_W-1:0]    r_long_hold;
    logic [HOLD_W-1:0]    r_short_hold;

    // Sequencer state
    t_step                r_step,       n_step;
    logic [BIT_IDX_W-1:0] r_bit_idx,    n_bit_idx;
    logic [HOLD_W-1:0]    r_hold_cnt,   n_hold_cnt;
    logic [TMO_W-1:0]     r_poll_cnt,   n_poll_cnt;
    logic [DATA_W-1:0]    r_shift,      n_shift;
    logic                 r_ack_choice, n_ack_choice;
    logic                 r_scl,        n_scl;
    logic                 r_sda,        n_sda;
    t_ack_status          r_status,     n_status;
    logic [DATA_W-1:0]    r_read_res,   n_read_res;
    logic                 r_done,       n_done;
    logic                 r_out_valid;

    logic                 w_accept;
    logic [HOLD_W-1:0]    w_hold_long;
    logic [HOLD_W-1:0]    w_hold_short;

    // Input side is ready when the pending result is gone or goes this cycle
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    // A zero hold register acts as one tick
    assign w_hold_long  = (r_long_hold == '0)  ? HOLD_W'(1) : r_long_hold;
    assign w_hold_short = (r_short_hold == '0) ? HOLD_W'(1) : r_short_hold;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_hold  <= LONG_HOLD_RST;
            r_short_hold <= SHORT_HOLD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LONG_HOLD:  r_long_hold  <= i_cfg.data;
                CFG_SHORT_HOLD: r_short_hold <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // One sequencer step per accepted tick
    always_comb begin
        logic  do_enter;
        t_step enter_step;
        logic  do_finish;

        n_step       = r_step;
        n_bit_idx    = r_bit_idx;
        n_hold_cnt   = r_hold_cnt;
        n_poll_cnt   = r_poll_cnt;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_status     = r_status;
        n_read_res   = r_read_res;
        n_done       = 1'b0;
        do_enter     = 1'b0;
        enter_step   = ST_IDLE;
        do_finish    = 1'b0;

        if (r_step == ST_IDLE) begin
            // Take a new command and drive its first phase on this tick
            if (i_cmd.cmd_valid) begin
                n_bit_idx = '1;
                case (i_cmd.func)
                    FN_START: begin
                        do_enter   = 1'b1;
                        enter_step = ST_A1;
                    end
                    FN_STOP: begin
                        do_enter   = 1'b1;
                        enter_step = ST_P1;
                    end
                    FN_WRITE: begin
                        n_shift    = i_cmd.write_data;
                        do_enter   = 1'b1;
                        enter_step = ST_W_LOW;
                    end
                    FN_WAIT_ACK: begin
                        n_poll_cnt = i_cmd.ack_timeout;
                        do_enter   = 1'b1;
                        enter_step = ST_K1;
                    end
                    FN_READ: begin
                        n_shift      = '0;
                        n_ack_choice = i_cmd.send_ack;
                        do_enter     = 1'b1;
                        enter_step   = ST_R_LOW;
                    end
                    default: n_bit_idx = r_bit_idx; // undefined code: stay idle
                endcase
            end
        end else if (r_hold_cnt > HOLD_W'(1)) begin
            n_hold_cnt = r_hold_cnt - HOLD_W'(1);
        end else begin
            // Hold has run out: advance to the next phase
            unique case (r_step)
                ST_A1: begin do_enter = 1'b1; enter_step = ST_A2; end
                ST_A2: begin n_scl = 1'b0; do_finish = 1'b1; end
                ST_P1: begin do_enter = 1'b1; enter_step = ST_P2; end
                ST_P2: begin do_enter = 1'b1; enter_step = ST_P3; end
                ST_P3: do_finish = 1'b1;
                ST_W_LOW: begin do_enter = 1'b1; enter_step = ST_W_HIGH; end
                ST_W_HIGH: begin
                    if (r_bit_idx == '0) begin
                        n_scl     = 1'b0;
                        n_sda     = 1'b1;
                        do_finish = 1'b1;
                    end else begin
                        n_bit_idx  = r_bit_idx - BIT_IDX_W'(1);
                        do_enter   = 1'b1;
                        enter_step = ST_W_LOW;
                    end
                end
                ST_K1: begin do_enter = 1'b1; enter_step = ST_K2; end
                ST_K2: begin do_enter = 1'b1; enter_step = ST_K_POLL; end
                ST_K_POLL: begin
                    if (r_poll_cnt == '0) begin
                        n_status  = ACK_TIMEOUT;
                        do_finish = 1'b1;
                    end else begin
                        n_poll_cnt = r_poll_cnt - TMO_W'(1);
                        do_enter   = 1'b1;
                        enter_step = i_cmd.sda_in ? ST_K_POLL : ST_K_CHECK;
                    end
                end
                ST_K_CHECK: begin
                    if (i_cmd.sda_in) begin
                        n_status  = ACK_NACK;
                        do_finish = 1'b1;
                    end else begin
                        do_enter   = 1'b1;
                        enter_step = ST_K_DROP;
                    end
                end
                ST_K_DROP: begin n_status = ACK_OK; do_finish = 1'b1; end
                ST_R_LOW: begin do_enter = 1'b1; enter_step = ST_R_HIGH; end
                ST_R_HIGH: begin
                    do_enter = 1'b1;
                    if (r_bit_idx == '0) begin
                        enter_step = ST_R_GAP;
                    end else begin
                        n_bit_idx  = r_bit_idx - BIT_IDX_W'(1);
                        enter_step = ST_R_LOW;
                    end
                end
                ST_R_GAP: begin do_enter = 1'b1; enter_step = ST_R_ACK; end
                ST_R_ACK: begin do_enter = 1'b1; enter_step = ST_R_END; end
                ST_R_END: begin
                    n_sda      = 1'b1;
                    n_read_res = r_shift;
                    do_finish  = 1'b1;
                end
                default: do_finish = 1'b1;
            endcase
        end

        // Enter a phase: drive its pins, sample where needed, load its hold
        if (do_enter) begin
            n_step     = enter_step;
            n_hold_cnt = w_hold_long;
            unique case (enter_step)
                ST_A1: begin n_scl = 1'b1; n_sda = 1'b1; end
                ST_A2: n_sda = 1'b0;
                ST_P1: begin n_scl = 1'b0; n_sda = 1'b0; end
                ST_P2: begin n_scl = 1'b1; n_hold_cnt = w_hold_short; end
                ST_P3: n_sda = 1'b1;
                ST_W_LOW: begin
                    n_scl = 1'b0;
                    n_sda = n_shift[n_bit_idx];
                end
                ST_W_HIGH: n_scl = 1'b1;
                ST_K1: begin n_sda = 1'b1; n_hold_cnt = w_hold_short; end
                ST_K2: begin n_scl = 1'b1; n_hold_cnt = w_hold_short; end
                ST_K_POLL: ;
                ST_K_CHECK: n_scl = 1'b1;
                ST_K_DROP: n_scl = 1'b0;
                ST_R_LOW: n_scl = 1'b0;
                ST_R_HIGH: begin
                    n_scl = 1'b1;
                    if (i_cmd.sda_in) begin
                        n_shift[n_bit_idx] = 1'b1;
                    end
                end
                ST_R_GAP: n_scl = 1'b0;
                ST_R_ACK: begin n_sda = !r_ack_choice; n_scl = 1'b1; end
                ST_R_END: n_scl = 1'b0;
                default: do_finish = 1'b1;
            endcase
        end

        if (do_finish) begin
            n_step     = ST_IDLE;
            n_bit_idx  = '1;
            n_hold_cnt = '0;
            n_done     = 1'b1;
        end
    end

    // State advances only on an accepted tick; it doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ST_IDLE;
            r_bit_idx    <= '1;
            r_hold_cnt   <= '0;
            r_poll_cnt   <= '0;
            r_shift      <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_status     <= ACK_OK;
            r_read_res   <= '0;
            r_done       <= 1'b0;
        end else if (w_accept) begin
            r_step       <= n_step;
            r_bit_idx    <= n_bit_idx;
            r_hold_cnt   <= n_hold_cnt;
            r_poll_cnt   <= n_poll_cnt;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_status     <= n_status;
            r_read_res   <= n_read_res;
            r_done       <= n_done;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.scl_out    = r_scl;
    assign o_res.sda_out    = r_sda;
    assign o_res.busy_res   = (r_step != ST_IDLE);
    assign o_res.done_res   = r_done;
    assign o_res.read_data  = r_read_res;
    assign o_res.ack_status = r_status;

endmodule : i2c_master_bit_engine_unit
`default_nettype wire
